[src/edit_distance_engine_unit_defines.svh]
// assertion macros shared by the checker
`ifndef EDIT_DISTANCE_ENGINE_UNIT_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_UNIT_DEFINES_SVH

// property checked outside reset
`define EED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every edge, reset included
`define EED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/eed_pkg.sv]
package eed_pkg;

  // longest string held on either side
  localparam int MAX_LEN = 64;
  // counter and cost width, holds 0 .. MAX_LEN
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int OUT_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int FUNC_W  = 2;

  localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MAX_LEN);

  // item function codes
  localparam logic [FUNC_W-1:0] FN_REF    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TYPED  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FINISH = 2'd2;

  // data handed from one cell to the next
  typedef struct packed {
    logic              chr;       // typed character step
    logic              tok;       // finish token
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  cost_new;  // updated cost of left column, or distance so far
    logic [LEN_W-1:0]  cost_old;  // cost of left column before the update
  } link_t;

  // reference load control broadcast to all cells
  typedef struct packed {
    logic              wr;
    logic [LEN_W-1:0]  count;
    logic [CHAR_W-1:0] ch;
  } bcast_t;

  // counter to output field width
  function automatic logic [OUT_W-1:0] to_out(input logic [LEN_W-1:0] v);
    return OUT_W'(v);
  endfunction

endpackage

[src/eed_in_if.sv]
interface eed_in_if import eed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink (input valid, input func, input char_code, output ready);
endinterface

[src/eed_out_if.sv]
interface eed_out_if import eed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] distance;
  logic [OUT_W-1:0] ref_length;
  logic [OUT_W-1:0] typed_length;
  logic             error;

  modport source (output valid, output distance, output ref_length, output typed_length,
                  output error, input ready);
  modport sink (input valid, input distance, input ref_length, input typed_length,
                input error, output ready);
endinterface

[src/eed_head.sv]
module eed_head import eed_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [FUNC_W-1:0] func,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              clear,
  output link_t             link_o,
  output bcast_t            bc,
  output logic [LEN_W-1:0]  ref_count,
  output logic [LEN_W-1:0]  typed_count,
  output logic              error_flag
);

  // reference load is legal only before typing starts and while there is room
  assign bc.wr    = acc && (func == FN_REF) && (typed_count == '0) && (ref_count != MAX_CNT);
  assign bc.count = ref_count;
  assign bc.ch    = char_code;

  // counters, error flag and column zero of the cost row
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count   <= '0;
      typed_count <= '0;
      error_flag  <= 1'b0;
      link_o      <= '0;
    end else begin
      link_o.chr      <= 1'b0;
      link_o.tok      <= 1'b0;
      link_o.ch       <= char_code;
      link_o.cost_old <= typed_count;
      link_o.cost_new <= typed_count + LEN_W'(1);
      if (clear) begin
        ref_count   <= '0;
        typed_count <= '0;
        error_flag  <= 1'b0;
      end else if (acc) begin
        unique case (func)
          FN_REF: begin
            if (bc.wr) begin
              ref_count <= ref_count + LEN_W'(1);
            end else begin
              error_flag <= 1'b1;
            end
          end
          FN_TYPED: begin
            if (typed_count == MAX_CNT) begin
              error_flag <= 1'b1;
            end else begin
              typed_count <= typed_count + LEN_W'(1);
              link_o.chr  <= 1'b1;
            end
          end
          FN_FINISH: begin
            // token starts with cost_row[0], the distance for an empty reference
            link_o.tok      <= 1'b1;
            link_o.cost_new <= typed_count;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[src/eed_cell.sv]
module eed_cell import eed_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] cell_index,
  input  bcast_t           bc,
  input  link_t            link_i,
  output link_t            link_o
);

  logic [CHAR_W-1:0] ref_ch;
  logic [LEN_W-1:0]  cost;
  logic [LEN_W-1:0]  min_ab;
  logic [LEN_W-1:0]  min_abc;
  logic [LEN_W-1:0]  fresh;
  logic [LEN_W-1:0]  init_cost;
  logic              live;

  // this cell holds reference char cell_index and cost_row[cell_index + 1]
  assign init_cost = cell_index + LEN_W'(1);
  assign live      = cell_index < bc.count;

  // one step of the recurrence
  always_comb begin
    min_ab  = (cost < link_i.cost_new) ? cost : link_i.cost_new;
    min_abc = (min_ab < link_i.cost_old) ? min_ab : link_i.cost_old;
    if (ref_ch == link_i.ch) begin
      fresh = link_i.cost_old;
    end else begin
      fresh = min_abc + LEN_W'(1);
    end
  end

  // reference character store
  always_ff @(posedge clk) begin
    if (bc.wr && (bc.count == cell_index)) begin
      ref_ch <= bc.ch;
    end
  end

  // cost update and hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cost   <= init_cost;
      link_o <= '0;
    end else begin
      link_o.chr      <= link_i.chr;
      link_o.tok      <= link_i.tok;
      link_o.ch       <= link_i.ch;
      link_o.cost_new <= link_i.cost_new;
      link_o.cost_old <= link_i.cost_old;
      if (link_i.chr) begin
        cost            <= fresh;
        link_o.cost_new <= fresh;
        link_o.cost_old <= cost;
      end else if (link_i.tok) begin
        // finish token picks up the last live column and clears the cell
        cost <= init_cost;
        if (live) begin
          link_o.cost_new <= cost;
        end
      end
    end
  end

endmodule

[src/edit_distance_engine_unit.sv]
// Levenshtein edit distance engine.
// in_ch carries items of func and char_code: func FN_REF appends a reference
// character, FN_TYPED appends a typed character, FN_FINISH emits the result;
// code 3 is ignored. Reference characters must all come before typed ones;
// overflow past MAX_LEN or a late reference character is dropped and sets error.
// The cost row lives in a chain of MAX_LEN cells; a typed character walks
// down the chain one cell per cycle, so typed and reference items are taken
// one per cycle, back to back, while no finish is in flight.
// A finish item follows the characters down the chain as a token, collects
// the distance and clears each cell; its result then goes to out_ch through
// the holding register. in_ch.ready stays low from the finish until the
// result enters the output register.
// If out_ch stalls, the result waits in the output register and a following
// result waits in a holding register; items resume once the holding register
// drains. Synchronous reset clears the counters, the error flag, the cost row
// and both output registers.
module edit_distance_engine_unit import eed_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  eed_in_if.sink    in_ch,
  eed_out_if.source out_ch
);

  link_t            links [0:MAX_LEN];
  bcast_t           bc;
  logic             acc;
  logic             busy;
  logic             tok_done;
  logic [LEN_W-1:0] ref_count;
  logic [LEN_W-1:0] typed_count;
  logic             error_flag;

  logic             pend_valid;
  logic [LEN_W-1:0] pend_dist;
  logic [LEN_W-1:0] pend_ref;
  logic [LEN_W-1:0] pend_typed;
  logic             pend_err;
  logic             pend_move;

  logic             out_valid;
  logic [OUT_W-1:0] out_dist;
  logic [OUT_W-1:0] out_ref;
  logic [OUT_W-1:0] out_typed;
  logic             out_err;

  assign in_ch.ready = !busy;
  assign acc         = in_ch.valid && !busy;
  assign tok_done    = links[MAX_LEN].tok;
  assign pend_move   = pend_valid && (!out_valid || out_ch.ready);

  eed_head u_head (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .func        (in_ch.func),
    .char_code   (in_ch.char_code),
    .clear       (tok_done),
    .link_o      (links[0]),
    .bc          (bc),
    .ref_count   (ref_count),
    .typed_count (typed_count),
    .error_flag  (error_flag)
  );

  // chain of cost cells
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    eed_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (LEN_W'(i)),
      .bc         (bc),
      .link_i     (links[i]),
      .link_o     (links[i+1])
    );
  end

  // finish in flight blocks new items
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (acc && (in_ch.func == FN_FINISH)) begin
      busy <= 1'b1;
    end else if (pend_move) begin
      busy <= 1'b0;
    end
  end

  // holding register at the end of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (tok_done) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_done) begin
      pend_dist  <= links[MAX_LEN].cost_new;
      pend_ref   <= ref_count;
      pend_typed <= typed_count;
      pend_err   <= error_flag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_dist  <= to_out(pend_dist);
      out_ref   <= to_out(pend_ref);
      out_typed <= to_out(pend_typed);
      out_err   <= pend_err;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.distance     = out_dist;
  assign out_ch.ref_length   = out_ref;
  assign out_ch.typed_length = out_typed;
  assign out_ch.error        = out_err;

endmodule

[src/eed_checker.sv]
`include "edit_distance_engine_unit_defines.svh"

module eed_checker import eed_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [OUT_W-1:0]  distance,
  input logic [OUT_W-1:0]  ref_length,
  input logic [OUT_W-1:0]  typed_length,
  input logic              err_flag
);

  logic [OUT_W-1:0] longer;
  logic [OUT_W:0]   dist_plus_typed;
  logic [OUT_W:0]   dist_plus_ref;

  assign longer          = (ref_length > typed_length) ? ref_length : typed_length;
  assign dist_plus_typed = {1'b0, distance} + {1'b0, typed_length};
  assign dist_plus_ref   = {1'b0, distance} + {1'b0, ref_length};

  // stalled result holds
  `EED_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(ref_length) && $stable(typed_length) && $stable(err_flag), "result changed while stalled")

  // distance lies between the length difference and the longer length
  `EED_ASSERT(a_dist_bounds, out_valid |-> (distance <= longer) && (dist_plus_typed >= {1'b0, ref_length}) && (dist_plus_ref >= {1'b0, typed_length}), "distance out of range")

  // a taken finish stops intake
  `EED_ASSERT(a_finish_blocks, in_valid && in_ready && (in_func == FN_FINISH) |=> !in_ready, "item taken during finish")

  // intake resumes only with a result on offer
  `EED_ASSERT(a_resume_result, $rose(in_ready) && !$past(rst) |-> out_valid, "intake resumed without result")

  // reset leaves the block empty and ready
  `EED_ASSERT_ALWAYS(a_reset_state, rst |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind edit_distance_engine_unit eed_checker u_eed_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_func      (in_ch.func),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .distance     (out_ch.distance),
  .ref_length   (out_ch.ref_length),
  .typed_length (out_ch.typed_length),
  .err_flag     (out_ch.error)
);

[tb/edit_distance_engine_unit_tb.sv]
`timescale 1ns / 100ps

module edit_distance_engine_unit_tb;
  import eed_pkg::*;

  // selector code that the block ignores
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int DRAIN_CYCLES = MAX_LEN + 8;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic [OUT_W-1:0] ref_length;
    logic [OUT_W-1:0] typed_length;
    logic             error;
  } edit_report_t;

  logic clk;
  logic rst;

  eed_in_if  in_ch();
  eed_out_if out_ch();

  edit_distance_engine_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the block state
  logic [CHAR_W-1:0] ref_text [MAX_LEN];
  logic [LEN_W-1:0]  cost_row [MAX_LEN+1];
  logic [LEN_W-1:0]  ref_cnt;
  logic [LEN_W-1:0]  typed_cnt;
  logic              drop_flag;

  edit_report_t expected_reports[$];

  int sender_idle_pct;
  int recv_idle_pct;
  bit holding_off;
  event hold_off_ev;

  int cycle_count;
  int mismatches;
  int items_sent;
  int reports_checked;
  int reports_flagged;
  int longest_ref;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reports still awaited", cycle_count,
             expected_reports.size());
    $display("tb: failure");
    $finish;
  end

  // clear the shadow state, as after reset or a finish
  function automatic void clear_edit_state();
    for (int k = 0; k <= MAX_LEN; k++) cost_row[k] = LEN_W'(k);
    foreach (ref_text[i]) ref_text[i] = '0;
    ref_cnt   = '0;
    typed_cnt = '0;
    drop_flag = 1'b0;
  endfunction

  // advance the shadow state by one accepted item
  function automatic void score_keystroke(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] above;
    logic [LEN_W-1:0] fresh;
    logic [LEN_W-1:0] low;
    edit_report_t     rep;
    case (f)
      FN_REF: begin
        if (typed_cnt != 0 || ref_cnt >= MAX_CNT) begin
          drop_flag = 1'b1;
        end else begin
          ref_text[ref_cnt] = c;
          ref_cnt++;
        end
      end
      FN_TYPED: begin
        if (typed_cnt >= MAX_CNT) begin
          drop_flag = 1'b1;
        end else begin
          // one row of the dynamic-programming table
          diag = cost_row[0];
          cost_row[0] = typed_cnt + 1'b1;
          for (int k = 1; k <= ref_cnt; k++) begin
            above = cost_row[k];
            if (ref_text[k-1] == c) begin
              fresh = diag;
            end else begin
              low = (above < cost_row[k-1]) ? above : cost_row[k-1];
              low = (low < diag) ? low : diag;
              fresh = low + 1'b1;
            end
            diag = above;
            cost_row[k] = fresh;
          end
          typed_cnt++;
        end
      end
      FN_FINISH: begin
        rep.distance     = OUT_W'(cost_row[ref_cnt]);
        rep.ref_length   = OUT_W'(ref_cnt);
        rep.typed_length = OUT_W'(typed_cnt);
        rep.error        = drop_flag;
        expected_reports.insert(expected_reports.size(), rep);
        if (ref_cnt > longest_ref) longest_ref = ref_cnt;
        clear_edit_state();
      end
      default: begin
      end
    endcase
  endfunction

  // offer one item, wait for it to be taken, then update the shadow state
  task automatic send_item(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.char_code <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    score_keystroke(f, c);
    if (f != FN_UNUSED) items_sent++;
  endtask

  task automatic send_text(logic [FUNC_W-1:0] f, string s);
    for (int i = 0; i < s.len(); i++) send_item(f, s[i]);
  endtask

  // a character item, now and then preceded by an ignored selector
  task automatic send_char(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
    if ($urandom_range(99) < 3) send_item(FN_UNUSED, CHAR_W'($urandom_range(255)));
    send_item(f, c);
  endtask

  // receiver readiness, with a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || holding_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // hold-off length counted here
  initial begin
    holding_off = 1'b0;
    forever begin
      @(hold_off_ev);
      holding_off = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      holding_off = 1'b0;
    end
  end

  // compare each report with the oldest one predicted
  always @(posedge clk) begin
    edit_report_t want;
    edit_report_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.distance     = out_ch.distance;
      got.ref_length   = out_ch.ref_length;
      got.typed_length = out_ch.typed_length;
      got.error        = out_ch.error;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report at cycle %0d: dist %0d ref %0d typed %0d err %0b",
                   cycle_count, got.distance, got.ref_length, got.typed_length, got.error);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (want.error) reports_flagged++;
        if (got.distance !== want.distance || got.ref_length !== want.ref_length ||
            got.typed_length !== want.typed_length || got.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: expected dist %0d ref %0d typed %0d err %0b,",
                      " got dist %0d ref %0d typed %0d err %0b"},
                     cycle_count, want.distance, want.ref_length, want.typed_length,
                     want.error, got.distance, got.ref_length, got.typed_length, got.error);
        end
      end
    end
  end

  // finish with nothing loaded, and ignored selectors in between
  task automatic test_empty_and_unused();
    send_item(FN_FINISH, 8'h00);
    send_item(FN_UNUSED, 8'hFF);
    send_item(FN_UNUSED, 8'h00);
    send_item(FN_FINISH, 8'hFF);
  endtask

  // lowest and highest character bytes
  task automatic test_char_extremes();
    send_item(FN_REF, 8'h00);
    send_item(FN_REF, 8'hFF);
    send_item(FN_TYPED, 8'hFF);
    send_item(FN_TYPED, 8'h00);
    send_item(FN_FINISH, 8'h00);
  endtask

  task automatic test_known_words();
    send_text(FN_REF, "flaw");
    send_text(FN_TYPED, "lawn");
    send_item(FN_FINISH, 8'h00);
  endtask

  // reference character after typing has begun is dropped
  task automatic test_late_reference();
    send_item(FN_REF, "a");
    send_item(FN_TYPED, "b");
    send_item(FN_REF, "c");
    send_item(FN_FINISH, 8'h00);
  endtask

  task automatic test_typed_only();
    send_text(FN_TYPED, "xy");
    send_item(FN_FINISH, 8'h00);
  endtask

  // one word: reference, a typed attempt at it, finish
  task automatic send_random_word();
    logic [CHAR_W-1:0] word[$];
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] c;
    bit narrow;
    int mode;
    int ref_len;
    int typed_len;
    int r;
    mode   = $urandom_range(99);
    base   = CHAR_W'($urandom_range(255));
    narrow = ($urandom_range(3) != 0);
    if (mode < 6) ref_len = $urandom_range(MAX_LEN + 4, MAX_LEN - 2);
    else if (mode < 11) ref_len = 0;
    else ref_len = $urandom_range(10, 1);
    // reference, from a narrow alphabet most of the time so matches occur
    for (int i = 0; i < ref_len; i++) begin
      c = narrow ? (base ^ CHAR_W'($urandom_range(3))) : CHAR_W'($urandom_range(255));
      word.insert(word.size(), c);
      send_char(FN_REF, c);
    end
    if (mode >= 11 && mode < 17) begin
      // long typed run that may overflow
      typed_len = $urandom_range(MAX_LEN + 4, MAX_LEN - 2);
      for (int i = 0; i < typed_len; i++)
        send_char(FN_TYPED, narrow ? (base ^ CHAR_W'($urandom_range(3)))
                                   : CHAR_W'($urandom_range(255)));
    end else begin
      // typed copy with substitutions, deletions and insertions
      foreach (word[i]) begin
        r = $urandom_range(99);
        if (r < 60) begin
          send_char(FN_TYPED, word[i]);
        end else if (r < 75) begin
          send_char(FN_TYPED, word[i] ^ CHAR_W'($urandom_range(255, 1)));
        end else if (r >= 87) begin
          send_char(FN_TYPED, CHAR_W'($urandom_range(255)));
          send_char(FN_TYPED, word[i]);
        end
      end
      if (word.size() == 0 && $urandom_range(1))
        send_char(FN_TYPED, CHAR_W'($urandom_range(255)));
    end
    if ($urandom_range(99) < 5) send_char(FN_REF, CHAR_W'($urandom_range(255)));
    // now and then no finish, so the next word arrives out of order
    if ($urandom_range(99) >= 4) send_char(FN_FINISH, CHAR_W'($urandom_range(255)));
  endtask

  task automatic test_random_words(int tx_idle, int rx_idle, int count);
    int first;
    sender_idle_pct = tx_idle;
    recv_idle_pct   = rx_idle;
    first = items_sent;
    while (items_sent - first < count) send_random_word();
  endtask

  // receiver stops for a long stretch while short words keep coming
  task automatic test_output_stall();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    -> hold_off_ev;
    for (int w = 0; w < 6; w++) begin
      send_item(FN_REF, CHAR_W'($urandom_range(255)));
      send_item(FN_REF, CHAR_W'($urandom_range(255)));
      send_item(FN_TYPED, CHAR_W'($urandom_range(255)));
      send_item(FN_TYPED, CHAR_W'($urandom_range(255)));
      send_item(FN_FINISH, 8'h00);
    end
  endtask

  // main sequence
  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FN_REF;
    in_ch.char_code <= '0;
    sender_idle_pct = 15;
    recv_idle_pct   = 71;
    mismatches      = 0;
    items_sent      = 0;
    reports_checked = 0;
    reports_flagged = 0;
    longest_ref     = 0;
    clear_edit_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_unused();
    test_char_extremes();
    test_known_words();
    test_late_reference();
    test_typed_only();
    test_random_words(15, 71, 420);
    test_random_words(71, 15, 420);
    test_output_stall();
    test_random_words(0, 0, 420);
    in_ch.valid <= 1'b0;

    // drain
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_reports.size();

    $display("summary: %0d items over %0d cycles, %0d reports checked, %0d with error set",
             items_sent, cycle_count, reports_checked, reports_flagged);
    $display("summary: longest reference %0d, %0d failures", longest_ref, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
